// ===== hw/rtl/q2e_pkg.sv =====
// q2e_pkg: widths, stage types and constants for the quaternion to Euler
// angle pipeline. Used by the top level and the port checker.
package q2e_pkg;

   localparam int QW           = 16;  // input component width, Q1.15
   localparam int ROLL_W       = 15;  // roll/yaw width, Q3.12
   localparam int PITCH_W      = 14;  // pitch width, Q2.12
   localparam int PW           = 32;  // product width
   localparam int SW           = 34;  // sum-of-products width, Q.30
   localparam int SPW          = 31;  // unclamped pitch sine term width
   localparam int MW           = 30;  // magnitude of unclamped sine term
   localparam int CW           = 36;  // CORDIC x/y width
   localparam int AW           = 20;  // CORDIC angle accumulator, Q.16
   localparam int RW           = 16;  // rounded angle before saturation
   localparam int ROOT_W       = 31;  // square root result width
   localparam int REM_W        = 33;  // square root remainder width
   localparam int RAD_W        = 62;  // square root radicand width
   localparam int SQ_STEPS     = 31;  // one root bit per stage
   localparam int CORDIC_STEPS = 17;

   localparam logic signed [SW-1:0] ONE_Q30     = SW'(64'sd1073741824);
   localparam logic signed [SW-1:0] NEG_ONE_Q30 = -SW'(64'sd1073741824);
   localparam logic signed [AW-1:0] HALF_PI_Q16 = AW'(102944);
   localparam logic signed [RW-1:0] PI_Q12      = RW'(12868);
   localparam logic signed [RW-1:0] HALF_PI_Q12 = RW'(6434);

   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [AW-1:0] ang_type;

   typedef struct packed {
      cw_type  x;
      cw_type  y;
      ang_type z;
      logic    zero;
   } crd_type;

   // roll/yaw terms and pitch term riding along the square root stages
   typedef struct packed {
      logic signed [SW-1:0]  sr;
      logic signed [SW-1:0]  cr;
      logic signed [SW-1:0]  sy;
      logic signed [SW-1:0]  cy;
      logic signed [SPW-1:0] sp;
      logic                  clamp;
      logic                  neg;
   } carry_type;

   typedef struct packed {
      logic [RAD_W-1:0]  v;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic valid;
      logic clamp;
      logic neg;
   } tag_type;

   // arctan(2^-i) in Q.16
   function automatic ang_type atan_q16(input int i);
      ang_type r;
      case (i)
         0: r = AW'(51472);
         1: r = AW'(30386);
         2: r = AW'(16055);
         3: r = AW'(8150);
         4: r = AW'(4091);
         5: r = AW'(2047);
         6: r = AW'(1024);
         7: r = AW'(512);
         8: r = AW'(256);
         9: r = AW'(128);
         10: r = AW'(64);
         11: r = AW'(32);
         12: r = AW'(16);
         13: r = AW'(8);
         14: r = AW'(4);
         15: r = AW'(2);
         16: r = AW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Accepts one request per cycle while no result waits at the output.
// Depth is set by the 31-stage bit-per-stage square root feeding three parallel
// 17-stage unrolled CORDIC lanes for roll, pitch and yaw.
// The whole pipeline advances together; it holds while a result waits.
// Synchronous active-high reset clears all valid bits; data is not reset.
// Depends on q2e_pkg.
module quaternion_to_euler_angles (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [q2e_pkg::QW-1:0]        req_quat_w,
   input  logic signed [q2e_pkg::QW-1:0]        req_quat_x,
   input  logic signed [q2e_pkg::QW-1:0]        req_quat_y,
   input  logic signed [q2e_pkg::QW-1:0]        req_quat_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [q2e_pkg::ROLL_W-1:0]    rsp_roll_angle,
   output logic signed [q2e_pkg::PITCH_W-1:0]   rsp_pitch_angle,
   output logic signed [q2e_pkg::ROLL_W-1:0]    rsp_yaw_angle,
   output logic                                 rsp_pitch_clamped
);
   import q2e_pkg::*;

   function automatic sq_type sq_step(input sq_type a);
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] tr;
      sq_type           r;
      r2     = {a.rem, a.v[RAD_W-1 -: 2]};
      tr     = {2'b00, a.root, 2'b01};
      r.v    = {a.v[RAD_W-3:0], 2'b00};
      if (r2 >= tr) begin
         r.rem  = REM_W'(r2 - tr);
         r.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = r2[REM_W-1:0];
         r.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // quadrant pre-rotation so x is never negative
   function automatic crd_type pre_rot(input cw_type y, input cw_type x);
      crd_type r;
      r.zero = (x == '0) && (y == '0);
      r.x    = x;
      r.y    = y;
      r.z    = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.z = HALF_PI_Q16;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -HALF_PI_Q16;
         end
      end
      return r;
   endfunction

   function automatic crd_type cordic_step(input crd_type a, input int i);
      cw_type  dx;
      cw_type  dy;
      crd_type r;
      dx = a.y >>> i;
      dy = a.x >>> i;
      r  = a;
      if (a.y > 0) begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + atan_q16(i);
      end else begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - atan_q16(i);
      end
      return r;
   endfunction

   // Q.16 to Q.12, round half up, saturate to +-lim; a zero vector gives zero
   function automatic logic signed [RW-1:0] round_sat(input crd_type a,
                                                      input logic signed [RW-1:0] lim);
      ang_type               t;
      logic signed [RW-1:0]  r;
      t = (a.z + AW'(8)) >>> 4;
      r = RW'(t);
      if (a.zero) begin
         r = '0;
      end else if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: products
   logic                 v1_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // stage 2: sums of products in Q.30
   logic                 v2_ff;
   logic signed [SW-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_ff <= (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
         cr_ff <= ONE_Q30 - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
         sp_ff <= (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
         sy_ff <= (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
         cy_ff <= ONE_Q30 - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      end
   end

   // stage 3: pitch clamp and magnitude
   logic                 v3_ff;
   carry_type            c3_ff, c3_in;
   logic [MW-1:0]        mag3_ff, mag3_in;
   logic signed [SW-1:0] sp_abs;

   always_comb begin
      c3_in.sr    = sr_ff;
      c3_in.cr    = cr_ff;
      c3_in.sy    = sy_ff;
      c3_in.cy    = cy_ff;
      c3_in.clamp = (sp_ff >= ONE_Q30) || (sp_ff <= NEG_ONE_Q30);
      c3_in.neg   = sp_ff[SW-1];
      c3_in.sp    = c3_in.clamp ? '0 : sp_ff[SPW-1:0];
      sp_abs      = sp_ff[SW-1] ? -sp_ff : sp_ff;
      mag3_in     = c3_in.clamp ? '0 : sp_abs[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c3_ff   <= c3_in;
         mag3_ff <= mag3_in;
      end
   end

   // stage 4: square of the sine term
   logic               v4_ff;
   carry_type          c4_ff;
   logic [2*MW-1:0]    sq4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff  <= c3_ff;
         sq4_ff <= (2*MW)'(mag3_ff) * (2*MW)'(mag3_ff);
      end
   end

   // square root stages: index 0 loads 1 - s*s, then one root bit per stage
   logic      sv_ff  [0:SQ_STEPS];
   carry_type car_ff [0:SQ_STEPS];
   sq_type    sqs_ff [0:SQ_STEPS];
   sq_type    sq0_in;

   always_comb begin
      sq0_in.v    = (RAD_W'(1) << (2*MW)) - RAD_W'(sq4_ff);
      sq0_in.rem  = '0;
      sq0_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= c4_ff;
         sqs_ff[0] <= sq0_in;
      end
   end

   for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (adv) begin
            sv_ff[k] <= sv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            car_ff[k] <= car_ff[k-1];
            sqs_ff[k] <= sq_step(sqs_ff[k-1]);
         end
      end
   end

   // CORDIC: lane 0 roll, lane 1 pitch, lane 2 yaw
   tag_type tag_ff [0:CORDIC_STEPS];
   crd_type crd_ff [0:CORDIC_STEPS][0:2];
   tag_type tag0_in;
   cw_type  cos_p;

   always_comb begin
      tag0_in.valid = sv_ff[SQ_STEPS];
      tag0_in.clamp = car_ff[SQ_STEPS].clamp;
      tag0_in.neg   = car_ff[SQ_STEPS].neg;
      cos_p         = $signed({{(CW-ROOT_W){1'b0}}, sqs_ff[SQ_STEPS].root});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (adv) begin
         tag_ff[0] <= tag0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         crd_ff[0][0] <= pre_rot(CW'(car_ff[SQ_STEPS].sr), CW'(car_ff[SQ_STEPS].cr));
         crd_ff[0][1] <= pre_rot(CW'(car_ff[SQ_STEPS].sp), cos_p);
         crd_ff[0][2] <= pre_rot(CW'(car_ff[SQ_STEPS].sy), CW'(car_ff[SQ_STEPS].cy));
      end
   end

   for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (adv) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (adv) begin
               crd_ff[i][l] <= cordic_step(crd_ff[i-1][l], i - 1);
            end
         end
      end
   end

   // output register
   logic                      rsp_valid_ff;
   logic signed [ROLL_W-1:0]  roll_ff, roll_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [ROLL_W-1:0]  yaw_ff, yaw_in;
   logic                      clamp_ff;
   logic signed [RW-1:0]      pitch_r;

   always_comb begin
      roll_in = ROLL_W'(round_sat(crd_ff[CORDIC_STEPS][0], PI_Q12));
      yaw_in  = ROLL_W'(round_sat(crd_ff[CORDIC_STEPS][2], PI_Q12));
      if (tag_ff[CORDIC_STEPS].clamp) begin
         pitch_r = tag_ff[CORDIC_STEPS].neg ? -HALF_PI_Q12 : HALF_PI_Q12;
      end else begin
         pitch_r = round_sat(crd_ff[CORDIC_STEPS][1], HALF_PI_Q12);
      end
      pitch_in = PITCH_W'(pitch_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tag_ff[CORDIC_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         clamp_ff <= tag_ff[CORDIC_STEPS].clamp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clamped = clamp_ff;

endmodule

// ===== hw/rtl/q2e_checker.sv =====
// q2e_checker: port-level checks on the quaternion to Euler angle block,
// bound to the top level. Depends on q2e_pkg.
module q2e_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [q2e_pkg::ROLL_W-1:0]    rsp_roll_angle,
   input logic signed [q2e_pkg::PITCH_W-1:0]   rsp_pitch_angle,
   input logic signed [q2e_pkg::ROLL_W-1:0]    rsp_yaw_angle,
   input logic                                 rsp_pitch_clamped
);
   import q2e_pkg::*;

   // a clamp always shows as exactly +-pi/2
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clamped |->
         (rsp_pitch_angle == PITCH_W'(HALF_PI_Q12)) ||
         (rsp_pitch_angle == -PITCH_W'(HALF_PI_Q12)))
      else $error("clamped pitch is not +-pi/2");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_roll_angle <= ROLL_W'(PI_Q12)) && (rsp_roll_angle >= -ROLL_W'(PI_Q12)) &&
         (rsp_yaw_angle <= ROLL_W'(PI_Q12)) && (rsp_yaw_angle >= -ROLL_W'(PI_Q12)) &&
         (rsp_pitch_angle <= PITCH_W'(HALF_PI_Q12)) &&
         (rsp_pitch_angle >= -PITCH_W'(HALF_PI_Q12)))
      else $error("angle out of range");

   // with no result pending the pipeline must take requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_angle) &&
         $stable(rsp_pitch_angle) && $stable(rsp_yaw_angle) && $stable(rsp_pitch_clamped))
      else $error("stalled result changed");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);

// ===== tb/sv/quaternion_to_euler_angles_test.sv =====
// Self-checking testbench for quaternion_to_euler_angles: drives quaternions,
// predicts roll/pitch/yaw with a bit-exact CORDIC model and checks each result.
// Depends on q2e_pkg and the quaternion_to_euler_angles RTL.
module quaternion_to_euler_angles_test;
   timeunit 1ns;
   timeprecision 1ps;
   import q2e_pkg::*;

   localparam int PIPE_LAT = 55;
   localparam longint ONE30 = 64'sd1 << 30;
   localparam longint HPI16 = 102944;
   localparam longint PI12 = 12868;
   localparam longint HPI12 = 6434;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ROLL_W-1:0]  yaw;
      logic                      clamped;
   } angles_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [QW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0,
      req_quat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [ROLL_W-1:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic rsp_pitch_clamped;

   angles_type expected_angles[$];
   int errors = 0;
   bit rx_idle_on = 1;
   bit tx_idle_on = 1;
   int hold_off = 0;

   quaternion_to_euler_angles u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint asr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_atan2(longint y, longint x);
      longint z = 0, t, dx, dy;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HPI16;
         end else begin
            t = x; x = -y; y = t; z = -HPI16;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = asr_floor(y, i);
         dy = asr_floor(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_q16(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_q16(i));
         end
      end
      return z;
   endfunction

   function automatic longint round_sat(longint zq16, longint lim);
      longint r = (zq16 + 8) >>> 4;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic angles_type euler_of(logic signed [QW-1:0] qw, qx, qy, qz);
      longint w = qw, x = qx, y = qy, z = qz;
      longint sr, cr, sp, sy, cy, p;
      angles_type a;
      sr = 2 * (w * x + y * z);
      cr = ONE30 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = ONE30 - 2 * (y * y + z * z);
      a.roll = ROLL_W'(round_sat(cordic_atan2(sr, cr), PI12));
      a.yaw = ROLL_W'(round_sat(cordic_atan2(sy, cy), PI12));
      if (sp >= ONE30 || sp <= -ONE30) begin
         p = (sp > 0) ? HPI12 : -HPI12;
         a.clamped = 1;
      end else begin
         p = round_sat(cordic_atan2(sp,
            floor_sqrt((64'd1 << 60) - longint'(sp * sp))), HPI12);
         a.clamped = 0;
      end
      a.pitch = PITCH_W'(p);
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // one request; random idle burst ahead of it
   task automatic send_quat(logic signed [QW-1:0] w, x, y, z);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      expected_angles.push_back(euler_of(w, x, y, z));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   task automatic rand_send(bit unit);
      int s;
      int c;
      if (!unit) begin
         send_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
         return;
      end
      // roughly unit length: three random parts, fourth from the remainder
      c = $urandom_range(0, 3);
      begin
         longint v[4];
         longint acc = 0;
         for (int i = 0; i < 4; i++) begin
            if (i == c) continue;
            s = $urandom_range(0, 32767);
            v[i] = ($urandom_range(0, 1) ? -1 : 1) * s / int'(1 + $urandom_range(0, 2));
            acc += v[i] * v[i];
         end
         v[c] = (acc >= ONE30) ? 0 : floor_sqrt(ONE30 - acc);
         if (v[c] > 32767) v[c] = 32767;
         if ($urandom_range(0, 1)) v[c] = -v[c];
         send_quat(QW'(v[0]), QW'(v[1]), QW'(v[2]), QW'(v[3]));
      end
   endtask

   task automatic test_directed();
      send_quat(16'sd32767, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_quat(23170, 0, 23170, 0);        // pitch term just below one: no clamp
      send_quat(23170, 0, -23170, 0);       // pitch term just above minus one: no clamp
      send_quat(0, 23170, 0, 23170);        // zx term dominates
      send_quat(0, 32767, 0, 0);            // roll = +pi
      send_quat(0, 0, 0, 32767);            // yaw = +pi
      send_quat(0, 0, 32767, 0);            // both atan2 terms on negative x
      send_quat(0, 16384, 0, 0);            // non-unit length
      send_quat(-16'sd32768, 0, 0, 0);
      send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
      send_quat(1, -1, 1, -1);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(16384, -16384, 16384, -16384);
      send_quat(32767, 0, 0, 1);            // sy tiny, cy positive
      send_quat(0, 32767, 0, -1);
   endtask

   task automatic test_random_unit();
      repeat (300) rand_send($urandom_range(0, 4) != 0);
   endtask

   // receiver stops long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      hold_off = 150;
      repeat (100) rand_send(1);
      wait_drained();
      repeat (20) @(posedge clock);
   endtask

   task automatic test_streaming();
      tx_idle_on = 0;
      rx_idle_on = 0;
      repeat (80) rand_send($urandom_range(0, 1));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random_unit();
      wait_drained();
      test_backpressure();
      test_streaming();
      wait_drained();
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (errors == 0 && expected_angles.size() == 0)
         $display("** quaternion_to_euler_angles: PASSED **");
      else
         $display("** quaternion_to_euler_angles: FAILED **");
      $finish;
   end

   // receiver ready, with idle bursts and one long hold-off
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            hold_off--;
         end else if (gap > 0) begin
            rsp_ready <= 0;
            gap--;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 0;
            gap = $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_roll_angle !== want.roll)
               report_mismatch("roll", rsp_roll_angle, want.roll);
            if (rsp_pitch_angle !== want.pitch)
               report_mismatch("pitch", rsp_pitch_angle, want.pitch);
            if (rsp_yaw_angle !== want.yaw)
               report_mismatch("yaw", rsp_yaw_angle, want.yaw);
            if (rsp_pitch_clamped !== want.clamped)
               report_mismatch("clamp", rsp_pitch_clamped, want.clamped);
         end
      end
   end

   initial begin
      #400us;
      $display("** quaternion_to_euler_angles: FAILED **");
      $finish;
   end
endmodule
